>>> hw/rtl/tmi_pkg.sv
`default_nettype none

package tmi_pkg;

	localparam int CELL_COUNT_DEF   = 256;
	localparam int LOOP_DEPTH_DEF   = 1024;
	localparam int PROGRAM_SIZE_DEF = 2048;

	localparam int PC_W   = 12;
	localparam int SKIP_W = 12;
	localparam int CELL_W = 8;

	localparam logic [SKIP_W-1:0] SKIP_MAX = '1;

	localparam logic [7:0] CMD_RIGHT = 8'h3E;
	localparam logic [7:0] CMD_LEFT  = 8'h3C;
	localparam logic [7:0] CMD_INC   = 8'h2B;
	localparam logic [7:0] CMD_DEC   = 8'h2D;
	localparam logic [7:0] CMD_PUTC  = 8'h2E;
	localparam logic [7:0] CMD_GETC  = 8'h2C;
	localparam logic [7:0] CMD_PUTD  = 8'h5F;
	localparam logic [7:0] CMD_OPEN  = 8'h5B;
	localparam logic [7:0] CMD_CLOSE = 8'h5D;

	localparam logic [1:0] OUT_NONE = 2'd0;
	localparam logic [1:0] OUT_CHAR = 2'd1;
	localparam logic [1:0] OUT_DEC  = 2'd2;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_PTR_HIGH  = 3'd1;
	localparam logic [2:0] ERR_PTR_LOW   = 3'd2;
	localparam logic [2:0] ERR_UNMATCHED = 3'd3;
	localparam logic [2:0] ERR_STACK     = 3'd4;

endpackage

`default_nettype wire

>>> hw/rtl/tmi_ram.sv
`default_nettype none

module tmi_ram #(
	parameter int DW    = 8,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> hw/rtl/tape_machine_interpreter_core_unit.sv
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_valid / cfg_ready  cfg_data (program length, 12 bits)
// in        in         in_valid / in_ready    instr, in_byte
// out       out        out_valid / out_ready  next_pc, out_kind, out_byte, halted, error_code
//
// Each request is executed in the cycle it is accepted and its result is registered,
// so it appears in the next cycle; one request per cycle is sustained while out_ready is high.
// The current cell and the top of the loop stack are read from memories with a registered
// read port, so a moved pointer or a pop is read back for the next request.
// After reset a clearing pass writes zero to every tape cell; no request is accepted
// during the pass, while configuration writes are always accepted.
// Outside the clearing pass, a new request is accepted whenever the output register is empty or being drained.
`default_nettype none

module tape_machine_interpreter_core_unit
	import tmi_pkg::*;
#(
	parameter int CELL_COUNT   = CELL_COUNT_DEF,
	parameter int LOOP_DEPTH   = LOOP_DEPTH_DEF,
	parameter int PROGRAM_SIZE = PROGRAM_SIZE_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [PC_W-1:0]   cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        instr,
	input  wire logic [7:0]        in_byte,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [PC_W-1:0]   next_pc,
	output logic      [1:0]        out_kind,
	output logic      [CELL_W-1:0] out_byte,
	output logic                   halted,
	output logic      [2:0]        error_code
);

	localparam int CW  = $clog2(CELL_COUNT);
	localparam int SW  = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;
	localparam int CTW = $clog2(LOOP_DEPTH + 1);

	logic [PC_W-1:0]   len_q;
	logic [PC_W-1:0]   pc_q;
	logic [CW-1:0]     cp_q;
	logic [SKIP_W-1:0] skip_q;
	logic [CTW-1:0]    cnt_q;
	logic              stop_q;
	logic [2:0]        err_q;
	logic [CELL_W-1:0] cell_q;
	logic              csel_q;
	logic [PC_W-1:0]   top_q;
	logic              tsel_q;
	logic              clear_q;
	logic [CW-1:0]     clr_idx_q;

	logic              out_valid_q;
	logic [PC_W-1:0]   next_pc_q;
	logic [1:0]        out_kind_q;
	logic [CELL_W-1:0] out_byte_q;
	logic              halted_q;
	logic [2:0]        error_code_q;

	logic [CELL_W-1:0] tape_rd;
	logic [PC_W-1:0]   stk_rd;
	logic [CELL_W-1:0] cur_cell;
	logic [PC_W-1:0]   top;
	logic              acc;

	logic [PC_W-1:0]   pc_d;
	logic [CW-1:0]     cp_d;
	logic [SKIP_W-1:0] skip_d;
	logic [CTW-1:0]    cnt_d;
	logic              stop_d;
	logic [2:0]        err_d;
	logic [1:0]        kind_d;
	logic [CELL_W-1:0] emit_d;
	logic              twr_d;
	logic [CELL_W-1:0] twd_d;
	logic              push_d;
	logic              pop_d;
	logic              moved_d;
	logic              at_end;
	logic              end_next;

	logic              tape_we;
	logic [CW-1:0]     tape_waddr;
	logic [CELL_W-1:0] tape_wdata;
	logic [CW-1:0]     tape_raddr;
	logic [CTW-1:0]    cnt_eff;
	logic [CTW-1:0]    cnt_m1;

	assign cfg_ready = 1'b1;
	assign in_ready  = !clear_q && (!out_valid_q || out_ready);
	assign acc       = in_valid && in_ready;

	assign cur_cell = csel_q ? tape_rd : cell_q;
	assign top      = tsel_q ? stk_rd : top_q;

	assign at_end   = (32'(pc_q) >= 32'(len_q)) || (32'(pc_q) >= 32'(PROGRAM_SIZE));
	assign end_next = (32'(pc_d) >= 32'(len_q)) || (32'(pc_d) >= 32'(PROGRAM_SIZE));

	always_comb begin
		pc_d    = pc_q;
		cp_d    = cp_q;
		skip_d  = skip_q;
		cnt_d   = cnt_q;
		stop_d  = stop_q;
		err_d   = err_q;
		kind_d  = OUT_NONE;
		emit_d  = '0;
		twr_d   = 1'b0;
		twd_d   = cur_cell;
		push_d  = 1'b0;
		pop_d   = 1'b0;
		moved_d = 1'b0;
		if (!stop_q && at_end) begin
			stop_d = 1'b1;
		end else if (!stop_q) begin
			pc_d = pc_q + PC_W'(1);
			if (skip_q != '0) begin
				if (instr == CMD_OPEN) begin
					if (skip_q != SKIP_MAX) begin
						skip_d = skip_q + SKIP_W'(1);
					end
				end else if (instr == CMD_CLOSE) begin
					skip_d = skip_q - SKIP_W'(1);
				end
			end else begin
				unique case (instr)
					CMD_RIGHT: begin
						if (cp_q == CW'(CELL_COUNT - 1)) begin
							stop_d = 1'b1;
							err_d  = ERR_PTR_HIGH;
							pc_d   = pc_q;
						end else begin
							cp_d    = cp_q + CW'(1);
							moved_d = 1'b1;
						end
					end
					CMD_LEFT: begin
						if (cp_q == '0) begin
							stop_d = 1'b1;
							err_d  = ERR_PTR_LOW;
							pc_d   = pc_q;
						end else begin
							cp_d    = cp_q - CW'(1);
							moved_d = 1'b1;
						end
					end
					CMD_INC: begin
						twr_d = 1'b1;
						twd_d = cur_cell + CELL_W'(1);
					end
					CMD_DEC: begin
						twr_d = 1'b1;
						twd_d = cur_cell - CELL_W'(1);
					end
					CMD_PUTC: begin
						kind_d = OUT_CHAR;
						emit_d = cur_cell;
					end
					CMD_PUTD: begin
						kind_d = OUT_DEC;
						emit_d = cur_cell;
					end
					CMD_GETC: begin
						twr_d = 1'b1;
						twd_d = in_byte;
					end
					CMD_OPEN: begin
						if (cur_cell == '0) begin
							skip_d = SKIP_W'(1);
						end else if (cnt_q == CTW'(LOOP_DEPTH)) begin
							stop_d = 1'b1;
							err_d  = ERR_STACK;
							pc_d   = pc_q;
						end else begin
							push_d = 1'b1;
							cnt_d  = cnt_q + CTW'(1);
						end
					end
					CMD_CLOSE: begin
						if (cur_cell != '0) begin
							if (cnt_q == '0) begin
								stop_d = 1'b1;
								err_d  = ERR_UNMATCHED;
								pc_d   = pc_q;
							end else begin
								pc_d = top + PC_W'(1);
							end
						end else if (cnt_q != '0) begin
							pop_d = 1'b1;
							cnt_d = cnt_q - CTW'(1);
						end
					end
					default: begin
					end
				endcase
			end
			if (!stop_d && end_next) begin
				stop_d = 1'b1;
			end
		end
	end

	assign tape_we    = clear_q || (acc && twr_d);
	assign tape_waddr = clear_q ? clr_idx_q : cp_q;
	assign tape_wdata = clear_q ? '0 : twd_d;
	assign tape_raddr = acc ? cp_d : cp_q;
	assign cnt_eff    = acc ? cnt_d : cnt_q;
	assign cnt_m1     = cnt_eff - CTW'(1);

	tmi_ram #(
		.DW    (CELL_W),
		.DEPTH (CELL_COUNT),
		.AW    (CW)
	) u_tape (
		.clk   (clk),
		.we    (tape_we),
		.waddr (tape_waddr),
		.wdata (tape_wdata),
		.raddr (tape_raddr),
		.rdata (tape_rd)
	);

	tmi_ram #(
		.DW    (PC_W),
		.DEPTH (LOOP_DEPTH),
		.AW    (SW)
	) u_stack (
		.clk   (clk),
		.we    (acc && push_d),
		.waddr (cnt_q[SW-1:0]),
		.wdata (pc_q),
		.raddr (cnt_m1[SW-1:0]),
		.rdata (stk_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			pc_q        <= '0;
			cp_q        <= '0;
			skip_q      <= '0;
			cnt_q       <= '0;
			stop_q      <= 1'b0;
			err_q       <= ERR_NONE;
			cell_q      <= '0;
			csel_q      <= 1'b0;
			top_q       <= '0;
			tsel_q      <= 1'b0;
			clear_q     <= 1'b1;
			clr_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				len_q <= cfg_data;
			end
			if (clear_q) begin
				if (clr_idx_q == CW'(CELL_COUNT - 1)) begin
					clear_q <= 1'b0;
				end else begin
					clr_idx_q <= clr_idx_q + CW'(1);
				end
			end
			if (acc) begin
				pc_q        <= pc_d;
				cp_q        <= cp_d;
				skip_q      <= skip_d;
				cnt_q       <= cnt_d;
				stop_q      <= stop_d;
				err_q       <= err_d;
				out_valid_q <= 1'b1;
				if (twr_d) begin
					cell_q <= twd_d;
					csel_q <= 1'b0;
				end else if (moved_d) begin
					csel_q <= 1'b1;
				end
				if (push_d) begin
					top_q  <= pc_q;
					tsel_q <= 1'b0;
				end else if (pop_d) begin
					tsel_q <= 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			next_pc_q    <= pc_d;
			out_kind_q   <= kind_d;
			out_byte_q   <= emit_d;
			halted_q     <= stop_d;
			error_code_q <= err_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign next_pc    = next_pc_q;
	assign out_kind   = out_kind_q;
	assign out_byte   = out_byte_q;
	assign halted     = halted_q;
	assign error_code = error_code_q;

	a_stop_sticky : assert property (@(posedge clk) disable iff (!arst_n)
		stop_q |=> stop_q)
		else $error("Core restarted after stopping.");

	a_error_stops : assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ERR_NONE) |-> stop_q)
		else $error("Error code recorded without a stop.");

	a_stack_bound : assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= 32'(LOOP_DEPTH))
		else $error("Loop stack count beyond its depth.");

	a_no_accept_clearing : assert property (@(posedge clk) disable iff (!arst_n)
		clear_q |-> !(in_valid && in_ready))
		else $error("Request accepted during the tape clearing pass.");

endmodule

`default_nettype wire

>>> tb/tape_machine_interpreter_core_unit_tb.sv
module tape_machine_interpreter_core_unit_tb;
	import tmi_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RET_PC    = 1300;
	localparam int unsigned LOW_TOP   = 700;
	localparam int unsigned STACK_CAP = 40;
	localparam int unsigned HOLD_LEN  = 300;

	typedef struct packed {
		logic [PC_W-1:0]   next_pc;
		logic [1:0]        kind;
		logic [CELL_W-1:0] value;
		logic              halted;
		logic [2:0]        err;
	} tm_result_t;

	typedef struct packed {
		logic [7:0] op;
		logic [7:0] data;
		logic       typed;
		tm_result_t want;
	} cmd_row_t;

	typedef enum int unsigned {
		END_ZERO_LEN,
		END_LENGTH,
		END_PTR_HIGH,
		END_PTR_LOW,
		END_UNMATCHED,
		END_STACK_FULL
	} ending_t;

	localparam cmd_row_t DIR_TAB [22] = '{
		'{CMD_CLOSE, 8'h00, 1'b1, '{12'd1, OUT_NONE, 8'h00, 1'b0, ERR_NONE}},
		'{CMD_PUTC,  8'h00, 1'b1, '{12'd2, OUT_CHAR, 8'h00, 1'b0, ERR_NONE}},
		'{CMD_DEC,   8'h00, 1'b1, '{12'd3, OUT_NONE, 8'h00, 1'b0, ERR_NONE}},
		'{CMD_PUTD,  8'h00, 1'b1, '{12'd4, OUT_DEC,  8'hFF, 1'b0, ERR_NONE}},
		'{CMD_INC,   8'h00, 1'b0, '0},
		'{CMD_GETC,  8'hFF, 1'b0, '0},
		'{CMD_PUTC,  8'h00, 1'b1, '{12'd7, OUT_CHAR, 8'hFF, 1'b0, ERR_NONE}},
		'{CMD_GETC,  8'h80, 1'b0, '0},
		'{CMD_PUTD,  8'h00, 1'b1, '{12'd9, OUT_DEC,  8'h80, 1'b0, ERR_NONE}},
		'{CMD_OPEN,  8'h00, 1'b0, '0},
		'{CMD_RIGHT, 8'h00, 1'b0, '0},
		'{CMD_OPEN,  8'h00, 1'b0, '0},
		'{CMD_OPEN,  8'h00, 1'b0, '0},
		'{CMD_RIGHT, 8'h00, 1'b0, '0},
		'{CMD_CLOSE, 8'h00, 1'b0, '0},
		'{8'h41,     8'h00, 1'b0, '0},
		'{CMD_CLOSE, 8'h00, 1'b0, '0},
		'{8'h00,     8'hFF, 1'b0, '0},
		'{8'hFF,     8'h00, 1'b0, '0},
		'{CMD_LEFT,  8'h00, 1'b0, '0},
		'{CMD_CLOSE, 8'h00, 1'b1, '{12'd10, OUT_NONE, 8'h00, 1'b0, ERR_NONE}},
		'{CMD_PUTC,  8'h00, 1'b1, '{12'd11, OUT_CHAR, 8'h80, 1'b0, ERR_NONE}}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [PC_W-1:0]   cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [7:0]        instr = '0;
	logic [7:0]        in_byte = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [PC_W-1:0]   next_pc;
	logic [1:0]        out_kind;
	logic [CELL_W-1:0] out_byte;
	logic              halted;
	logic [2:0]        error_code;

	logic [7:0]        tape_m [CELL_COUNT_DEF];
	int unsigned       cp_m = 0;
	int unsigned       pc_m = 0;
	logic [SKIP_W-1:0] skip_m = '0;
	logic [10:0]       stack_m [LOOP_DEPTH_DEF];
	int unsigned       depth_m = 0;
	logic              stopped_m = 1'b0;
	logic [2:0]        err_m = ERR_NONE;
	logic [PC_W-1:0]   prog_len = '0;

	tm_result_t        predicted_steps [$];
	tm_result_t        got_r;
	tm_result_t        want_r;
	int unsigned       send_idle_pct = 0;
	int unsigned       recv_idle_pct = 0;
	int unsigned       hold_reqs = 0;
	int unsigned       hold_seen = 0;
	int unsigned       hold_left = 0;
	int unsigned       fail_cnt = 0;

	tape_machine_interpreter_core_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.instr      (instr),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.next_pc    (next_pc),
		.out_kind   (out_kind),
		.out_byte   (out_byte),
		.halted     (halted),
		.error_code (error_code)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic tm_result_t interpret_cmd(input logic [7:0] op, input logic [7:0] data);
		tm_result_t  r;
		int unsigned lim;
		int unsigned nxt;
		lim = (prog_len > PROGRAM_SIZE_DEF) ? PROGRAM_SIZE_DEF : prog_len;
		r = '0;
		r.kind = OUT_NONE;
		nxt = pc_m;
		if (!stopped_m && pc_m >= lim)
			stopped_m = 1'b1;
		if (!stopped_m) begin
			nxt = pc_m + 1;
			if (skip_m != 0) begin
				if (op == CMD_OPEN) begin
					if (skip_m != SKIP_MAX)
						skip_m++;
				end else if (op == CMD_CLOSE) begin
					skip_m--;
				end
			end else begin
				case (op)
					CMD_RIGHT: begin
						if (cp_m == CELL_COUNT_DEF - 1) begin
							stopped_m = 1'b1;
							err_m = ERR_PTR_HIGH;
							nxt = pc_m;
						end else begin
							cp_m++;
						end
					end
					CMD_LEFT: begin
						if (cp_m == 0) begin
							stopped_m = 1'b1;
							err_m = ERR_PTR_LOW;
							nxt = pc_m;
						end else begin
							cp_m--;
						end
					end
					CMD_INC: tape_m[cp_m] = tape_m[cp_m] + 8'd1;
					CMD_DEC: tape_m[cp_m] = tape_m[cp_m] - 8'd1;
					CMD_PUTC: begin
						r.kind = OUT_CHAR;
						r.value = tape_m[cp_m];
					end
					CMD_PUTD: begin
						r.kind = OUT_DEC;
						r.value = tape_m[cp_m];
					end
					CMD_GETC: tape_m[cp_m] = data;
					CMD_OPEN: begin
						if (tape_m[cp_m] == 0) begin
							skip_m = 1;
						end else if (depth_m >= LOOP_DEPTH_DEF) begin
							stopped_m = 1'b1;
							err_m = ERR_STACK;
							nxt = pc_m;
						end else begin
							stack_m[depth_m] = 11'(pc_m);
							depth_m++;
						end
					end
					CMD_CLOSE: begin
						if (tape_m[cp_m] != 0) begin
							if (depth_m == 0) begin
								stopped_m = 1'b1;
								err_m = ERR_UNMATCHED;
								nxt = pc_m;
							end else begin
								nxt = stack_m[depth_m - 1] + 1;
							end
						end else if (depth_m != 0) begin
							depth_m--;
						end
					end
					default: ;
				endcase
			end
			pc_m = nxt;
			if (!stopped_m && pc_m >= lim)
				stopped_m = 1'b1;
		end
		r.next_pc = 12'(pc_m);
		r.halted = stopped_m;
		r.err = err_m;
		return r;
	endfunction

	// Random commands that keep the program running: no pointer or bracket faults, and the
	// program counter is pulled back through the loop stack before it nears the end.
	task automatic pick_cmd(input int unsigned ret_pc, input bit no_loops,
			output logic [7:0] op, output logic [7:0] data);
		int unsigned roll;
		logic [7:0]  cur_cell;
		cur_cell = tape_m[cp_m];
		roll = $urandom_range(99);
		data = ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(255));
		if (pc_m >= ret_pc) begin
			if (skip_m != 0) begin
				op = CMD_CLOSE;
			end else if (depth_m >= 2 && stack_m[depth_m - 1] >= LOW_TOP) begin
				op = (cur_cell != 0) ? CMD_GETC : CMD_CLOSE;
				data = 8'h00;
			end else begin
				op = (cur_cell == 0) ? CMD_INC : CMD_CLOSE;
			end
		end else if (skip_m != 0) begin
			if (roll < 35)
				op = CMD_CLOSE;
			else if (roll < 45 && skip_m < 8)
				op = CMD_OPEN;
			else
				op = 8'($urandom_range(255));
		end else begin
			if (roll < 10)
				op = CMD_RIGHT;
			else if (roll < 20)
				op = CMD_LEFT;
			else if (roll < 32)
				op = CMD_INC;
			else if (roll < 44)
				op = CMD_DEC;
			else if (roll < 50)
				op = CMD_PUTC;
			else if (roll < 56)
				op = CMD_PUTD;
			else if (roll < 66)
				op = CMD_GETC;
			else if (roll < 78)
				op = CMD_OPEN;
			else if (roll < 90)
				op = CMD_CLOSE;
			else
				op = 8'($urandom_range(255));
			if (op == CMD_RIGHT && cp_m == CELL_COUNT_DEF - 1)
				op = CMD_LEFT;
			if (op == CMD_LEFT && cp_m == 0)
				op = CMD_RIGHT;
			if (op == CMD_OPEN && cur_cell != 0 && depth_m >= STACK_CAP)
				op = CMD_CLOSE;
			if (op == CMD_CLOSE && cur_cell == 0 && depth_m <= 1)
				op = CMD_DEC;
			if (op == CMD_CLOSE && cur_cell != 0 && depth_m == 0)
				op = CMD_INC;
			if (no_loops && (op == CMD_OPEN || op == CMD_CLOSE))
				op = CMD_PUTC;
		end
	endtask

	task automatic send_cmd(input logic [7:0] op, input logic [7:0] data, input logic typed,
			input tm_result_t want);
		tm_result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		instr <= op;
		in_byte <= data;
		do @(posedge clk); while (!in_ready);
		r = interpret_cmd(op, data);
		predicted_steps.push_back(typed ? want : r);
		@(negedge clk);
	endtask

	task automatic write_len(input logic [PC_W-1:0] v);
		in_valid <= 1'b0;
		while (predicted_steps.size() != 0)
			@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		prog_len = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_random(input int unsigned n);
		logic [7:0] op;
		logic [7:0] data;
		repeat (n) begin
			pick_cmd(RET_PC, 1'b0, op, data);
			send_cmd(op, data, 1'b0, '0);
		end
	endtask

	task automatic run_to_stop(input ending_t how);
		logic [7:0] op;
		logic [7:0] data;
		logic [7:0] cur_cell;
		while (!stopped_m) begin
			cur_cell = tape_m[cp_m];
			data = 8'($urandom_range(255, 1));
			case (how)
				END_ZERO_LEN, END_LENGTH: pick_cmd(4096, 1'b1, op, data);
				END_PTR_HIGH: op = (skip_m != 0) ? CMD_CLOSE : CMD_RIGHT;
				END_PTR_LOW: op = (skip_m != 0) ? CMD_CLOSE : CMD_LEFT;
				END_UNMATCHED: begin
					if (skip_m != 0) begin
						op = CMD_CLOSE;
					end else if (depth_m != 0) begin
						op = (cur_cell != 0) ? CMD_GETC : CMD_CLOSE;
						data = 8'h00;
					end else begin
						op = (cur_cell == 0) ? CMD_GETC : CMD_CLOSE;
					end
				end
				default: begin
					if (skip_m != 0)
						op = CMD_CLOSE;
					else
						op = (cur_cell == 0) ? CMD_INC : CMD_OPEN;
				end
			endcase
			send_cmd(op, data, 1'b0, '0);
		end
	endtask

	task automatic note_mismatch(input string what, input tm_result_t want, input tm_result_t got);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("%s: expected pc=%0d kind=%0d byte=%02h halted=%0b err=%0d,",
				what, want.next_pc, want.kind, want.value, want.halted, want.err,
				" got pc=%0d kind=%0d byte=%02h halted=%0b err=%0d",
				got.next_pc, got.kind, got.value, got.halted, got.err);
	endtask

	always @(negedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_LEN;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_r = {next_pc, out_kind, out_byte, halted, error_code};
			if (predicted_steps.size() == 0) begin
				note_mismatch("result with no request", '0, got_r);
			end else begin
				want_r = predicted_steps.pop_front();
				if (got_r !== want_r)
					note_mismatch("result mismatch", want_r, got_r);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin : main_seq
		logic [7:0] op;
		logic [7:0] data;
		ending_t    how;
		foreach (tape_m[i])
			tape_m[i] = '0;
		foreach (stack_m[i])
			stack_m[i] = '0;
		send_idle_pct = 20;
		recv_idle_pct = 84;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		write_len(12'hFFF);

		foreach (DIR_TAB[i])
			send_cmd(DIR_TAB[i].op, DIR_TAB[i].data, DIR_TAB[i].typed, DIR_TAB[i].want);
		run_random(620);

		send_idle_pct = 84;
		recv_idle_pct = 20;
		write_len(12'd0);
		write_len(12'd1800);
		run_random(620);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_len(12'(PROGRAM_SIZE_DEF));
		hold_reqs++;
		run_random(600);

		while (pc_m >= 800) begin
			pick_cmd(0, 1'b0, op, data);
			send_cmd(op, data, 1'b0, '0);
		end
		how = ending_t'($urandom_range(5));
		if (how == END_ZERO_LEN)
			write_len(12'd0);
		else if (how == END_LENGTH)
			write_len(12'(pc_m + 16));
		run_to_stop(how);
		repeat (6)
			send_cmd(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0, '0);

		in_valid <= 1'b0;
		while (predicted_steps.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> tape_machine_interpreter_core_unit.f
hw/rtl/tmi_pkg.sv
hw/rtl/tmi_ram.sv
hw/rtl/tape_machine_interpreter_core_unit.sv
tb/tape_machine_interpreter_core_unit_tb.sv
